/* hdl/iwcd_pkg.sv */
// Shared types, constants and calendar helpers for the ISO week to calendar date unit.
package iwcd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned WEEK_W  = 6;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MUL_W   = 15;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned DOY_W   = 10;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  localparam logic [WEEK_W-1:0] WEEK_MIN = 6'd1;
  localparam logic [WEEK_W-1:0] WEEK_MAX = 6'd53;

  // Reciprocals: x / 100 = (x * RECIP_100) >> 19 for x <= 10000,
  // x / 7 = (x * RECIP_7) >> 17 for x below about 43000.
  localparam logic [MUL_W-1:0] RECIP_100 = 15'd5243;
  localparam int unsigned      SHIFT_100 = 19;
  localparam logic [MUL_W-1:0] RECIP_7   = 15'd18725;
  localparam int unsigned      SHIFT_7   = 17;
  localparam logic [MUL_W-1:0] CONST_100 = 15'd100;
  localparam logic [MUL_W-1:0] CONST_7   = 15'd7;

  localparam logic [2:0] WD_WED = 3'd3;
  localparam logic [2:0] WD_THU = 3'd4;

  localparam logic [WEEK_W-1:0]  WEEKS_LONG  = 6'd53;
  localparam logic [WEEK_W-1:0]  WEEKS_SHORT = 6'd52;
  localparam logic [8:0]         LEN_LEAP    = 9'd366;
  localparam logic [8:0]         LEN_COMMON  = 9'd365;
  localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV100,
    ST_CHK100,
    ST_SUM,
    ST_MOD7,
    ST_WDAY,
    ST_WEEKS,
    ST_DOY,
    ST_SPLIT,
    ST_WALK,
    ST_OUT
  } state_t;

  // Start of week 1 relative to January 1, by weekday of January 1 (0 is Sunday).
  function automatic logic signed [DOY_W-1:0] week_shift(input logic [2:0] wd);
    logic signed [DOY_W-1:0] s;
    case (wd)
      3'd0:    s = 10'sd1;
      3'd1:    s = 10'sd0;
      3'd2:    s = -10'sd1;
      3'd3:    s = -10'sd2;
      3'd4:    s = -10'sd3;
      3'd5:    s = 10'sd3;
      3'd6:    s = 10'sd2;
      default: s = 10'sd1;
    endcase
    return s;
  endfunction

  function automatic logic [8:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
    logic [8:0] len;
    case (m)
      MONTH_FEB:                  len = leap ? 9'd29 : 9'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 9'd30;
      default:                    len = 9'd31;
    endcase
    return len;
  endfunction

endpackage

/* hdl/iso_week_to_calendar_date_unit.sv */
// ISO week date to calendar date converter: sequencer around one shared multiplier.
//
// Input channel: in_week_year and in_week_number transfer when in_valid is high and
// in_stall is low. Out-of-range values are clamped (year 1..9999, week 1..53).
// Result channel: out_calendar_year, out_calendar_month and out_calendar_day, held
// in an output register while out_valid is high and out_stall is high.
// One item is in work at a time; in_stall stays high from the transfer until the
// result is loaded into the output register, so the next item can transfer while a
// finished result still waits downstream.
// The weekday and leap analysis of a year takes four passes through the shared 15x15
// multiplier (divide by 100, check, weekday sum times 1/7, times 7) followed by a step
// each for the weekday and the week count; a week 53 that rolls into the next year
// repeats it. The month walk then subtracts one month length per step, up to
// December; a Monday that moves into another year skips it.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops any result
// held in the output register. A stalled receiver holds the result in place; the
// block then finishes its current item and waits before loading the next result.
module iso_week_to_calendar_date_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [iwcd_pkg::YEAR_W-1:0]    in_week_year,
  input  logic [iwcd_pkg::WEEK_W-1:0]    in_week_number,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [iwcd_pkg::YEAR_W-1:0]    out_calendar_year,
  output logic [iwcd_pkg::MONTH_W-1:0]   out_calendar_month,
  output logic [iwcd_pkg::DAY_W-1:0]     out_calendar_day
);

  iwcd_pkg::state_t state_r, state_nxt;

  logic [iwcd_pkg::YEAR_W-1:0]  y_r, y_nxt;
  logic [iwcd_pkg::WEEK_W-1:0]  w_r, w_nxt;
  logic [iwcd_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [6:0]                   q100_r, q100_nxt;
  logic [iwcd_pkg::MUL_W-1:0]   s_r, s_nxt;
  logic [2:0]                   wd_r, wd_nxt;
  logic                         leap_r, leap_nxt;
  logic                         second_r, second_nxt;
  logic [8:0]                   d_r, d_nxt;
  logic [iwcd_pkg::MONTH_W-1:0] m_r, m_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [iwcd_pkg::YEAR_W-1:0]  out_year_r, out_year_nxt;
  logic [iwcd_pkg::MONTH_W-1:0] out_month_r, out_month_nxt;
  logic [iwcd_pkg::DAY_W-1:0]   out_day_r, out_day_nxt;

  // Shared multiplier operands.
  logic [iwcd_pkg::MUL_W-1:0]   mul_a, mul_b;

  logic                         div100;
  logic [iwcd_pkg::YEAR_W-1:0]  p_year;
  logic [6:0]                   p100;
  logic [iwcd_pkg::WEEK_W-1:0]  weeks;
  logic [8:0]                   ylen;
  logic signed [iwcd_pkg::DOY_W-1:0] doy;
  logic signed [iwcd_pkg::DOY_W-1:0] doy_prev;
  logic [8:0]                   mlen;
  logic                         slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iwcd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y_r         <= y_nxt;
    w_r         <= w_nxt;
    prod_r      <= prod_nxt;
    q100_r      <= q100_nxt;
    s_r         <= s_nxt;
    wd_r        <= wd_nxt;
    leap_r      <= leap_nxt;
    d_r         <= d_nxt;
    m_r         <= m_nxt;
    out_year_r  <= out_year_nxt;
    out_month_r <= out_month_nxt;
    out_day_r   <= out_day_nxt;
  end

  assign div100    = (prod_r == {{(iwcd_pkg::PROD_W - iwcd_pkg::YEAR_W){1'b0}}, y_r});
  assign p_year    = y_r - 14'd1;
  assign p100      = q100_r - {6'd0, div100};
  assign weeks     = ((wd_r == iwcd_pkg::WD_THU) || ((wd_r == iwcd_pkg::WD_WED) && leap_r))
                     ? iwcd_pkg::WEEKS_LONG : iwcd_pkg::WEEKS_SHORT;
  assign ylen      = leap_r ? iwcd_pkg::LEN_LEAP : iwcd_pkg::LEN_COMMON;
  assign doy       = $signed({1'b0, prod_r[8:0]}) + 10'sd1 + iwcd_pkg::week_shift(wd_r);
  assign doy_prev  = doy + 10'sd31;
  assign mlen      = iwcd_pkg::month_len(m_r, leap_r);
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    q100_nxt      = q100_r;
    s_nxt         = s_r;
    wd_nxt        = wd_r;
    leap_nxt      = leap_r;
    second_nxt    = second_r;
    d_nxt         = d_r;
    m_nxt         = m_r;
    out_year_nxt  = out_year_r;
    out_month_nxt = out_month_r;
    out_day_nxt   = out_day_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_a         = '0;
    mul_b         = '0;

    case (state_r)
      iwcd_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_week_year < iwcd_pkg::YEAR_MIN)      y_nxt = iwcd_pkg::YEAR_MIN;
          else if (in_week_year > iwcd_pkg::YEAR_MAX) y_nxt = iwcd_pkg::YEAR_MAX;
          else                                        y_nxt = in_week_year;
          if (in_week_number < iwcd_pkg::WEEK_MIN)      w_nxt = iwcd_pkg::WEEK_MIN;
          else if (in_week_number > iwcd_pkg::WEEK_MAX) w_nxt = iwcd_pkg::WEEK_MAX;
          else                                          w_nxt = in_week_number;
          second_nxt = 1'b0;
          state_nxt  = iwcd_pkg::ST_DIV100;
        end
      end
      iwcd_pkg::ST_DIV100: begin
        mul_a     = {1'b0, y_r};
        mul_b     = iwcd_pkg::RECIP_100;
        state_nxt = iwcd_pkg::ST_CHK100;
      end
      iwcd_pkg::ST_CHK100: begin
        // Multiply the quotient back to test divisibility by 100.
        q100_nxt  = prod_r[iwcd_pkg::SHIFT_100 +: 7];
        mul_a     = {8'd0, prod_r[iwcd_pkg::SHIFT_100 +: 7]};
        mul_b     = iwcd_pkg::CONST_100;
        state_nxt = iwcd_pkg::ST_SUM;
      end
      iwcd_pkg::ST_SUM: begin
        leap_nxt  = (y_r[1:0] == 2'd0) && (!div100 || (q100_r[1:0] == 2'd0));
        s_nxt     = {1'b0, p_year} + {3'd0, p_year[iwcd_pkg::YEAR_W-1:2]}
                    - {8'd0, p100} + {10'd0, p100[6:2]} + 15'd1;
        mul_a     = {1'b0, p_year} + {3'd0, p_year[iwcd_pkg::YEAR_W-1:2]}
                    - {8'd0, p100} + {10'd0, p100[6:2]} + 15'd1;
        mul_b     = iwcd_pkg::RECIP_7;
        state_nxt = iwcd_pkg::ST_MOD7;
      end
      iwcd_pkg::ST_MOD7: begin
        mul_a     = {4'd0, prod_r[iwcd_pkg::SHIFT_7 +: 11]};
        mul_b     = iwcd_pkg::CONST_7;
        state_nxt = iwcd_pkg::ST_WDAY;
      end
      iwcd_pkg::ST_WDAY: begin
        wd_nxt    = s_r[2:0] - prod_r[2:0];
        state_nxt = iwcd_pkg::ST_WEEKS;
      end
      iwcd_pkg::ST_WEEKS: begin
        // Week 53 of a short year: roll into the next year and analyze it.
        if (!second_r && (w_r > weeks)) begin
          w_nxt      = w_r - weeks;
          y_nxt      = y_r + 14'd1;
          second_nxt = 1'b1;
          state_nxt  = iwcd_pkg::ST_DIV100;
        end else begin
          state_nxt  = iwcd_pkg::ST_DOY;
        end
      end
      iwcd_pkg::ST_DOY: begin
        mul_a     = {9'd0, w_r - 6'd1};
        mul_b     = iwcd_pkg::CONST_7;
        state_nxt = iwcd_pkg::ST_SPLIT;
      end
      iwcd_pkg::ST_SPLIT: begin
        if (doy <= 10'sd0) begin
          // Monday lies in late December of the previous year.
          y_nxt     = y_r - 14'd1;
          m_nxt     = iwcd_pkg::MONTH_DEC;
          d_nxt     = doy_prev[8:0];
          state_nxt = iwcd_pkg::ST_OUT;
        end else if (doy > $signed({1'b0, ylen})) begin
          y_nxt     = y_r + 14'd1;
          m_nxt     = iwcd_pkg::MONTH_JAN;
          d_nxt     = doy[8:0] - ylen;
          state_nxt = iwcd_pkg::ST_OUT;
        end else begin
          m_nxt     = iwcd_pkg::MONTH_JAN;
          d_nxt     = doy[8:0];
          state_nxt = iwcd_pkg::ST_WALK;
        end
      end
      iwcd_pkg::ST_WALK: begin
        if ((m_r < iwcd_pkg::MONTH_DEC) && (d_r > mlen)) begin
          d_nxt = d_r - mlen;
          m_nxt = m_r + 4'd1;
        end else begin
          state_nxt = iwcd_pkg::ST_OUT;
        end
      end
      iwcd_pkg::ST_OUT: begin
        // Hold until the output register is free or being drained.
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = y_r;
          out_month_nxt = m_r;
          out_day_nxt   = d_r[iwcd_pkg::DAY_W-1:0];
          state_nxt     = iwcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = iwcd_pkg::ST_IDLE;
      end
    endcase

    prod_nxt = mul_a * mul_b;
  end

  assign in_stall           = (state_r != iwcd_pkg::ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_calendar_year  = out_year_r;
  assign out_calendar_month = out_month_r;
  assign out_calendar_day   = out_day_r;

endmodule

/* tb/monday_checker.sv */
// Checker for the ISO week to calendar date unit: predicts each Monday and compares results.
module monday_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [iwcd_pkg::YEAR_W-1:0]    in_week_year,
  input  logic [iwcd_pkg::WEEK_W-1:0]    in_week_number,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [iwcd_pkg::YEAR_W-1:0]    out_calendar_year,
  input  logic [iwcd_pkg::MONTH_W-1:0]   out_calendar_month,
  input  logic [iwcd_pkg::DAY_W-1:0]     out_calendar_day,
  output int                             fail_count,
  output int                             outstanding,
  output int                             mondays_checked,
  output int                             mondays_in_prior_year,
  output int                             mondays_in_later_year
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SUNDAY    = 0;
  localparam int MONDAY    = 1;
  localparam int TUESDAY   = 2;
  localparam int WEDNESDAY = 3;
  localparam int THURSDAY  = 4;
  localparam int FRIDAY    = 5;
  localparam int SATURDAY  = 6;

  localparam int FIRST_YEAR = 1;
  localparam int LAST_YEAR  = 9999;
  localparam int FIRST_WEEK = 1;
  localparam int LAST_WEEK  = 53;
  localparam int DECEMBER   = 12;

  typedef struct {
    logic [iwcd_pkg::YEAR_W-1:0]  week_year;
    logic [iwcd_pkg::WEEK_W-1:0]  week_number;
    logic [iwcd_pkg::YEAR_W-1:0]  year;
    logic [iwcd_pkg::MONTH_W-1:0] month;
    logic [iwcd_pkg::DAY_W-1:0]   day;
    int                           year_step;
  } monday_t;

  monday_t expected_mondays[$];

  function automatic bit gregorian_leap(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_year(input int y);
    return gregorian_leap(y) ? 366 : 365;
  endfunction

  function automatic int days_in_month(input int y, input int m);
    if (m == 2) return gregorian_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // Weekday of January 1, Sunday first.
  function automatic int jan1_dow(input int y);
    int p;
    p = y - 1;
    return (p + p / 4 - p / 100 + p / 400 + 1) % 7;
  endfunction

  function automatic monday_t predict_monday(input logic [iwcd_pkg::YEAR_W-1:0] wy,
                                             input logic [iwcd_pkg::WEEK_W-1:0] wn);
    monday_t res;
    int y, w, base, weeks, doy, m, d, shift;
    y = int'(wy);
    w = int'(wn);
    if (y < FIRST_YEAR) y = FIRST_YEAR;
    if (y > LAST_YEAR) y = LAST_YEAR;
    if (w < FIRST_WEEK) w = FIRST_WEEK;
    if (w > LAST_WEEK) w = LAST_WEEK;
    base = y;
    // Long years open on Thursday, or on Wednesday when leap.
    weeks = (jan1_dow(y) == THURSDAY || (jan1_dow(y) == WEDNESDAY && gregorian_leap(y)))
            ? 53 : 52;
    if (w > weeks) begin
      w = w - weeks;
      y = y + 1;
    end
    case (jan1_dow(y))
      SUNDAY:    shift = 1;
      MONDAY:    shift = 0;
      TUESDAY:   shift = -1;
      WEDNESDAY: shift = -2;
      THURSDAY:  shift = -3;
      FRIDAY:    shift = 3;
      SATURDAY:  shift = 2;
      default:   shift = 1;
    endcase
    doy = (w - 1) * 7 + 1 + shift;
    if (doy <= 0) begin
      y = y - 1;
      doy = doy + days_in_year(y);
    end else if (doy > days_in_year(y)) begin
      doy = doy - days_in_year(y);
      y = y + 1;
    end
    m = 1;
    d = doy;
    while (m < DECEMBER && d > days_in_month(y, m)) begin
      d = d - days_in_month(y, m);
      m = m + 1;
    end
    res.week_year   = wy;
    res.week_number = wn;
    res.year        = y[iwcd_pkg::YEAR_W-1:0];
    res.month       = m[iwcd_pkg::MONTH_W-1:0];
    res.day         = d[iwcd_pkg::DAY_W-1:0];
    res.year_step   = y - base;
    return res;
  endfunction

  initial begin
    fail_count            = 0;
    outstanding           = 0;
    mondays_checked       = 0;
    mondays_in_prior_year = 0;
    mondays_in_later_year = 0;
  end

  always @(posedge clk) begin : watch_channels
    monday_t want;
    bit      failed;
    failed = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_mondays.size() == 0) begin
          failed = 1'b1;
          if (fail_count < 10)
            $display("[%0t] unexpected result %0d-%0d-%0d", $realtime,
                     out_calendar_year, out_calendar_month, out_calendar_day);
        end else begin
          want = expected_mondays.pop_front();
          if (out_calendar_year !== want.year || out_calendar_month !== want.month ||
              out_calendar_day !== want.day) begin
            failed = 1'b1;
            if (fail_count < 10)
              $display("[%0t] year %0d week %0d: expected %0d-%0d-%0d, got %0d-%0d-%0d",
                       $realtime, want.week_year, want.week_number,
                       want.year, want.month, want.day,
                       out_calendar_year, out_calendar_month, out_calendar_day);
          end
          mondays_checked <= mondays_checked + 1;
          if (want.year_step < 0) mondays_in_prior_year <= mondays_in_prior_year + 1;
          if (want.year_step > 0) mondays_in_later_year <= mondays_in_later_year + 1;
        end
      end
      if (in_valid && !in_stall)
        expected_mondays.push_back(predict_monday(in_week_year, in_week_number));
    end
    if (failed) fail_count <= fail_count + 1;
    outstanding <= expected_mondays.size();
  end

endmodule

/* tb/testbench.sv */
// Top of the ISO week to calendar date testbench: clock, reset, traffic and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [iwcd_pkg::YEAR_W-1:0] year_t;
  typedef logic [iwcd_pkg::WEEK_W-1:0] week_t;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_WEEKS = 600;
  localparam int DRAIN_CYCLES = 40;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  year_t                        in_week_year = '0;
  week_t                        in_week_number = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [iwcd_pkg::YEAR_W-1:0]  out_calendar_year;
  logic [iwcd_pkg::MONTH_W-1:0] out_calendar_month;
  logic [iwcd_pkg::DAY_W-1:0]   out_calendar_day;

  logic calm = 1'b0;
  int   weeks_sent = 0;
  int   idle_cycles = 0;
  int   fail_count, outstanding, mondays_checked;
  int   mondays_in_prior_year, mondays_in_later_year;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  iso_week_to_calendar_date_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_week_year       (in_week_year),
    .in_week_number     (in_week_number),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_calendar_year  (out_calendar_year),
    .out_calendar_month (out_calendar_month),
    .out_calendar_day   (out_calendar_day)
  );

  monday_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_week_year          (in_week_year),
    .in_week_number        (in_week_number),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_calendar_year     (out_calendar_year),
    .out_calendar_month    (out_calendar_month),
    .out_calendar_day      (out_calendar_day),
    .fail_count            (fail_count),
    .outstanding           (outstanding),
    .mondays_checked       (mondays_checked),
    .mondays_in_prior_year (mondays_in_prior_year),
    .mondays_in_later_year (mondays_in_later_year)
  );

  // Mostly short gaps, now and then a long one; none while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_week(input year_t y, input week_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_week_year   <= y;
    in_week_number <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    weeks_sent++;
  endtask

  task automatic send_random_week();
    year_t y;
    week_t w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      y = year_t'($urandom_range(1, 9999));
      w = week_t'(($urandom_range(0, 2) == 0) ? $urandom_range(50, 53)
                                              : $urandom_range(1, 53));
    end else if (r < 87) begin
      y = year_t'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 5)
                                              : $urandom_range(9994, 10003));
      w = week_t'($urandom_range(0, 63));
    end else begin
      y = year_t'($urandom);
      w = week_t'($urandom);
    end
    send_week(y, w);
  endtask

  // Receiver back-pressure: ready stretches with short and occasional long stalls.
  initial begin : result_stall
    int r;
    forever begin
      r = $urandom_range(0, 99);
      if (calm || r < 60) begin
        out_stall <= 1'b0;
        repeat (calm ? 1 : $urandom_range(1, 8)) @(posedge clk);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAIL iso_week_to_calendar_date_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Clamping at the field extremes.
    send_week(14'd0, 6'd0);
    send_week(14'd16383, 6'd63);
    send_week(14'd10000, 6'd1);
    send_week(14'd1, 6'd1);
    send_week(14'd1, 6'd53);
    send_week(14'd9999, 6'd52);
    send_week(14'd9999, 6'd53);
    send_week(14'd9998, 6'd53);
    // January 1 on each weekday, first and last week.
    send_week(14'd2017, 6'd1);
    send_week(14'd2018, 6'd1);
    send_week(14'd2019, 6'd1);
    send_week(14'd2014, 6'd1);
    send_week(14'd2015, 6'd1);
    send_week(14'd2016, 6'd1);
    send_week(14'd2011, 6'd1);
    send_week(14'd2015, 6'd53);
    send_week(14'd2020, 6'd53);
    send_week(14'd2019, 6'd53);
    send_week(14'd2017, 6'd52);
    // Century leap rule.
    send_week(14'd2000, 6'd9);
    send_week(14'd1900, 6'd9);
    send_week(14'd2100, 6'd9);
    send_week(14'd2004, 6'd53);
    send_week(14'd42, 6'd32);

    for (int i = 0; i < RANDOM_WEEKS; i++) begin
      calm <= ((i / 50) % 4 == 3);
      send_random_week();
    end
    calm     <= 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d week dates; %0d Mondays checked, %0d in the prior year, %0d in the next.",
             weeks_sent, mondays_checked, mondays_in_prior_year, mondays_in_later_year);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS iso_week_to_calendar_date_unit");
    end else begin
      $display("%0d failures, %0d results missing", fail_count, outstanding);
      $display("FAIL iso_week_to_calendar_date_unit");
    end
    $finish;
  end

endmodule
